// ----- rtl/core/bsc_pkg.sv -----
// Shared types and constants for the barometric compensation core.
// Used by bsc_div and baro_sensor_compensation_core; depends on nothing.
`default_nettype none
package bsc_pkg;

  typedef struct packed {
    logic [19:0] raw_pressure;
    logic [19:0] raw_temperature;
  } in_t;

  typedef struct packed {
    logic signed [14:0] temperature_centi;
    logic [24:0]        pressure_q8;
    logic               pressure_valid;
  } out_t;

  typedef struct packed {
    logic signed [14:0] temp;
    logic               neg;
    logic               dz;
  } div_side_t;

  typedef enum logic [1:0] {
    CFG_TRIM_TEMP  = 2'd0,
    CFG_TRIM_PLOW  = 2'd1,
    CFG_TRIM_PHIGH = 2'd2,
    CFG_TRIM_PLAST = 2'd3
  } cfg_reg_e;

  localparam int NUM_W = 75;
  localparam int DEN_W = 39;
  localparam int QBITS = 35;
  localparam int REM_W = NUM_W - QBITS;
  localparam int QUO_W = QBITS + 1;

  localparam logic signed [14:0] TEMP_MIN  = -15'sd4000;
  localparam logic signed [14:0] TEMP_MAX  = 15'sd8500;
  localparam logic [24:0]        PRESS_MAX = 25'd33554431;

endpackage
`default_nettype wire

// ----- rtl/core/bsc_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, saturating quotient.
// Depends on bsc_pkg.
`default_nettype none
module bsc_div import bsc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  div_side_t        side_i,
  output logic             valid_o,
  output logic [QUO_W-1:0] quo_o,
  output div_side_t        side_o
);

  localparam logic [QUO_W-1:0] QUO_CAP = QUO_W'(1) << QBITS;

  logic [QBITS:0]   v_q;
  logic [REM_W-1:0] rem_q  [QBITS];
  logic [QBITS-1:0] low_q  [QBITS];
  logic [DEN_W-1:0] den_q  [QBITS];
  logic [QBITS-1:0] quo_q  [QBITS+1];
  logic             ovf_q  [QBITS+1];
  div_side_t        side_q [QBITS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[QBITS-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= num_i[NUM_W-1:QBITS];
      low_q[0]  <= num_i[QBITS-1:0];
      den_q[0]  <= den_i;
      quo_q[0]  <= '0;
      ovf_q[0]  <= num_i[NUM_W-1:QBITS] >= {1'b0, den_i};
      side_q[0] <= side_i;
    end
  end

  for (genvar g = 1; g <= QBITS; g++) begin : g_step
    logic [REM_W-1:0] trial;
    logic             ge;

    assign trial = {rem_q[g-1][REM_W-2:0], low_q[g-1][QBITS-1]};
    assign ge    = trial >= {1'b0, den_q[g-1]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[g]  <= {quo_q[g-1][QBITS-2:0], ge};
        ovf_q[g]  <= ovf_q[g-1];
        side_q[g] <= side_q[g-1];
      end
    end

    if (g < QBITS) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[g] <= ge ? trial - {1'b0, den_q[g-1]} : trial;
          low_q[g] <= {low_q[g-1][QBITS-2:0], 1'b0};
          den_q[g] <= den_q[g-1];
        end
      end
    end
  end

  assign valid_o = v_q[QBITS];
  assign quo_o   = ovf_q[QBITS] ? QUO_CAP : {1'b0, quo_q[QBITS]};
  assign side_o  = side_q[QBITS];

endmodule
`default_nettype wire

// ----- rtl/core/baro_sensor_compensation_core.sv -----
// Top level of the barometric compensation core: trim registers and datapath.
// Depends on bsc_pkg and bsc_div.
//
//   channel  | direction | handshake              | payload
//   in       | sink      | in_valid_i / in_ready_o   | in_t
//   out      | source    | out_valid_o / out_ready_i | out_t
//   cfg      | APB slave | psel, penable, pwrite     | pwdata / prdata, 64 bit
//
// One request per cycle while the skid register is empty; 11 trim arithmetic stages,
// 36 divider stages (overflow check, then one quotient bit each), 5 pressure stages.
// A skid register behind the result stage holds a refused result; the pipe
// freezes only while it is full. Reset clears valid bits and trim registers.
`default_nettype none
module baro_sensor_compensation_core import bsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [47:0] trim_t_q;
  logic [63:0] trim_pl_q;
  logic [63:0] trim_ph_q;
  logic [15:0] trim_p9_q;
  cfg_reg_e    cfg_sel;

  assign cfg_sel = cfg_reg_e'(paddr[4:3]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trim_t_q  <= '0;
      trim_pl_q <= '0;
      trim_ph_q <= '0;
      trim_p9_q <= '0;
    end else if (psel && penable && pwrite) begin
      case (cfg_sel)
        CFG_TRIM_TEMP:  trim_t_q  <= pwdata[47:0];
        CFG_TRIM_PLOW:  trim_pl_q <= pwdata;
        CFG_TRIM_PHIGH: trim_ph_q <= pwdata;
        CFG_TRIM_PLAST: trim_p9_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      CFG_TRIM_TEMP:  prdata = {16'd0, trim_t_q};
      CFG_TRIM_PLOW:  prdata = trim_pl_q;
      CFG_TRIM_PHIGH: prdata = trim_ph_q;
      CFG_TRIM_PLAST: prdata = {48'd0, trim_p9_q};
      default:        prdata = '0;
    endcase
  end

  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

  assign t1 = trim_t_q[15:0];
  assign t2 = $signed(trim_t_q[31:16]);
  assign t3 = $signed(trim_t_q[47:32]);
  assign p1 = trim_pl_q[15:0];
  assign p2 = $signed(trim_pl_q[31:16]);
  assign p3 = $signed(trim_pl_q[47:32]);
  assign p4 = $signed(trim_pl_q[63:48]);
  assign p5 = $signed(trim_ph_q[15:0]);
  assign p6 = $signed(trim_ph_q[31:16]);
  assign p7 = $signed(trim_ph_q[47:32]);
  assign p8 = $signed(trim_ph_q[63:48]);
  assign p9 = $signed(trim_p9_q);

  logic skid_q;
  logic en;

  assign en         = !skid_q;
  assign in_ready_o = en;

  logic [10:0] pv_q;
  logic [4:0]  qv_q;
  logic        dv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= '0;
      qv_q <= '0;
    end else if (en) begin
      pv_q <= {pv_q[9:0], in_valid_i};
      qv_q <= {qv_q[3:0], dv};
    end
  end

  // trim arithmetic
  logic signed [17:0] ta;
  logic signed [16:0] dd;
  logic signed [33:0] dsq_full;
  logic signed [33:0] s1_aprod_d, s1_aprod_q;
  logic [31:0]        s1_dsq_q;
  logic [19:0]        s1_adcp_q, s2_adcp_q, s3_adcp_q, s4_adcp_q, s5_adcp_q, s6_adcp_q;
  logic [19:0]        s7_adcp_q;
  logic signed [22:0] s2_a_q;
  logic signed [36:0] s2_bprod_d, s2_bprod_q;
  logic signed [23:0] s3_fine_d, s3_fine_q;
  logic signed [24:0] s4_v1_d, s4_v1_q;
  logic signed [26:0] tx;
  logic signed [18:0] tt;
  logic signed [14:0] s4_temp_d;
  logic signed [14:0] s4_temp_q, s5_temp_q, s6_temp_q, s7_temp_q, s8_temp_q, s9_temp_q;
  logic signed [49:0] v1sq_full;
  logic [45:0]        s5_v1sq_q;
  logic signed [40:0] s5_v1p5_d, s5_v1p2_d, s5_v1p5_q, s5_v1p2_q, s6_v1p5_q, s6_v1p2_q;
  logic signed [39:0] s6_pp6h_d, s6_pp6l_d, s6_pp3h_d, s6_pp3l_d;
  logic signed [39:0] s6_pp6h_q, s6_pp6l_q, s6_pp3h_q, s6_pp3l_q;
  logic signed [63:0] s7_v2_d, s7_v2_q, p3t, accw;
  logic signed [55:0] s7_acc_q;
  logic signed [48:0] s8_ph1_d, s8_ph1_q;
  logic [39:0]        s8_pl1_d, s8_pl1_q;
  logic [20:0]        dp;
  logic signed [63:0] s8_m_d, s8_m_q;
  logic signed [73:0] dsum;
  logic signed [39:0] s9_div_q;
  logic [62:0]        s9_um_q;
  logic               s9_mneg_q;
  logic [38:0]        s10_ud_q, s11_ud_q;
  logic [67:0]        s10_x_q;
  div_side_t          s10_side_q, s11_side_q;
  logic [74:0]        s11_num_q;

  assign ta         = $signed({1'b0, in_data_i.raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
  assign dd         = $signed({1'b0, in_data_i.raw_temperature[19:4]}) - $signed({1'b0, t1});
  assign s1_aprod_d = ta * t2;
  assign dsq_full   = dd * dd;
  assign s2_bprod_d = $signed({1'b0, s1_dsq_q[31:12]}) * t3;
  assign s3_fine_d  = s2_a_q + $signed(s2_bprod_q[36:14]);
  assign s4_v1_d    = s3_fine_q - 25'sd128000;
  assign tx         = s3_fine_q * 27'sd5 + 27'sd128;
  assign tt         = $signed(tx[26:8]);

  always_comb begin
    if (tt < 19'(TEMP_MIN)) begin
      s4_temp_d = TEMP_MIN;
    end else if (tt > 19'(TEMP_MAX)) begin
      s4_temp_d = TEMP_MAX;
    end else begin
      s4_temp_d = 15'(tt);
    end
  end

  assign v1sq_full = s4_v1_q * s4_v1_q;
  assign s5_v1p5_d = s4_v1_q * p5;
  assign s5_v1p2_d = s4_v1_q * p2;
  assign s6_pp6h_d = $signed({1'b0, s5_v1sq_q[45:23]}) * p6;
  assign s6_pp6l_d = $signed({1'b0, s5_v1sq_q[22:0]}) * p6;
  assign s6_pp3h_d = $signed({1'b0, s5_v1sq_q[45:23]}) * p3;
  assign s6_pp3l_d = $signed({1'b0, s5_v1sq_q[22:0]}) * p3;

  assign s7_v2_d = (64'(s6_pp6h_q) <<< 23) + 64'(s6_pp6l_q)
                 + (64'(s6_v1p5_q) <<< 17) + (64'(p4) <<< 35);
  assign p3t     = (64'(s6_pp3h_q) <<< 23) + 64'(s6_pp3l_q);
  assign accw    = (p3t >>> 8) + (64'(s6_v1p2_q) <<< 12) + (64'sd1 <<< 47);

  assign s8_ph1_d = $signed(s7_acc_q[55:24]) * $signed({1'b0, p1});
  assign s8_pl1_d = s7_acc_q[23:0] * p1;
  assign dp       = 21'd1048576 - {1'b0, s7_adcp_q};
  assign s8_m_d   = $signed(64'({dp, 31'd0})) - s7_v2_q;
  assign dsum     = (74'(s8_ph1_q) <<< 24) + $signed(74'(s8_pl1_q));

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_aprod_q <= s1_aprod_d;
      s1_dsq_q   <= dsq_full[31:0];
      s1_adcp_q  <= in_data_i.raw_pressure;

      s2_a_q     <= $signed(s1_aprod_q[33:11]);
      s2_bprod_q <= s2_bprod_d;
      s2_adcp_q  <= s1_adcp_q;

      s3_fine_q  <= s3_fine_d;
      s3_adcp_q  <= s2_adcp_q;

      s4_v1_q    <= s4_v1_d;
      s4_temp_q  <= s4_temp_d;
      s4_adcp_q  <= s3_adcp_q;

      s5_v1sq_q  <= v1sq_full[45:0];
      s5_v1p5_q  <= s5_v1p5_d;
      s5_v1p2_q  <= s5_v1p2_d;
      s5_temp_q  <= s4_temp_q;
      s5_adcp_q  <= s4_adcp_q;

      s6_pp6h_q  <= s6_pp6h_d;
      s6_pp6l_q  <= s6_pp6l_d;
      s6_pp3h_q  <= s6_pp3h_d;
      s6_pp3l_q  <= s6_pp3l_d;
      s6_v1p5_q  <= s5_v1p5_q;
      s6_v1p2_q  <= s5_v1p2_q;
      s6_temp_q  <= s5_temp_q;
      s6_adcp_q  <= s5_adcp_q;

      s7_v2_q    <= s7_v2_d;
      s7_acc_q   <= 56'(accw);
      s7_temp_q  <= s6_temp_q;
      s7_adcp_q  <= s6_adcp_q;

      s8_ph1_q   <= s8_ph1_d;
      s8_pl1_q   <= s8_pl1_d;
      s8_m_q     <= s8_m_d;
      s8_temp_q  <= s7_temp_q;

      s9_div_q   <= $signed(dsum[72:33]);
      s9_um_q    <= s8_m_q[63] ? 63'(-s8_m_q) : 63'(s8_m_q);
      s9_mneg_q  <= s8_m_q[63];
      s9_temp_q  <= s8_temp_q;

      s10_ud_q        <= s9_div_q[39] ? 39'(-s9_div_q) : 39'(s9_div_q);
      s10_x_q         <= 68'(s9_um_q) * 68'd25;
      s10_side_q.temp <= s9_temp_q;
      s10_side_q.neg  <= s9_mneg_q ^ s9_div_q[39];
      s10_side_q.dz   <= s9_div_q == '0;

      s11_num_q  <= 75'(s10_x_q) * 75'd125;
      s11_ud_q   <= s10_ud_q;
      s11_side_q <= s10_side_q;
    end
  end

  logic [QUO_W-1:0] dquo;
  div_side_t        dside;

  bsc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pv_q[10]),
    .num_i   (s11_num_q),
    .den_i   (s11_ud_q),
    .side_i  (s11_side_q),
    .valid_o (dv),
    .quo_o   (dquo),
    .side_o  (dside)
  );

  // pressure correction
  logic signed [36:0] q1_p_d, q1_p_q, q2_p_q, q3_p_q;
  div_side_t          q1_side_q, q2_side_q, q3_side_q, q4_side_q;
  logic signed [23:0] sv;
  logic signed [47:0] ssq_full;
  logic [44:0]        q2_ssq_q;
  logic signed [34:0] q2_ph8_d, q2_pl8_d, q2_ph8_q, q2_pl8_q;
  logic signed [37:0] q3_pp9h_d, q3_pp9h_q;
  logic signed [40:0] q3_pp9l_d, q3_pp9l_q;
  logic signed [55:0] c8w;
  logic signed [39:0] q3_c8_q;
  logic signed [63:0] c9w;
  logic signed [47:0] tot;
  logic signed [39:0] q4_pre_q;
  logic signed [40:0] pr;
  out_t               res_d, res_q, skid_data_q;

  assign q1_p_d    = dside.neg ? -$signed({1'b0, dquo}) : $signed({1'b0, dquo});
  assign sv        = $signed(q1_p_q[36:13]);
  assign ssq_full  = sv * sv;
  assign q2_ph8_d  = $signed(q1_p_q[36:18]) * p8;
  assign q2_pl8_d  = $signed({1'b0, q1_p_q[17:0]}) * p8;
  assign q3_pp9h_d = $signed({1'b0, q2_ssq_q[44:24]}) * p9;
  assign q3_pp9l_d = $signed({1'b0, q2_ssq_q[23:0]}) * p9;
  assign c8w       = (56'(q2_ph8_q) <<< 18) + 56'(q2_pl8_q);
  assign c9w       = ((64'(q3_pp9h_q) <<< 24) + 64'(q3_pp9l_q)) >>> 25;
  assign tot       = 48'(q3_p_q) + 48'(c9w) + 48'(q3_c8_q);
  assign pr        = 41'(q4_pre_q) + (41'(p7) <<< 4);

  always_comb begin
    res_d.temperature_centi = q4_side_q.temp;
    if (q4_side_q.dz || pr < 41'sd0) begin
      res_d.pressure_q8 = '0;
    end else if (pr > $signed(41'(PRESS_MAX))) begin
      res_d.pressure_q8 = PRESS_MAX;
    end else begin
      res_d.pressure_q8 = pr[24:0];
    end
    res_d.pressure_valid = res_d.pressure_q8 != '0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      q1_p_q    <= q1_p_d;
      q1_side_q <= dside;

      q2_ssq_q  <= ssq_full[44:0];
      q2_ph8_q  <= q2_ph8_d;
      q2_pl8_q  <= q2_pl8_d;
      q2_p_q    <= q1_p_q;
      q2_side_q <= q1_side_q;

      q3_pp9h_q <= q3_pp9h_d;
      q3_pp9l_q <= q3_pp9l_d;
      q3_c8_q   <= 40'(c8w >>> 19);
      q3_p_q    <= q2_p_q;
      q3_side_q <= q2_side_q;

      q4_pre_q  <= 40'(tot >>> 8);
      q4_side_q <= q3_side_q;

      res_q     <= res_d;
    end
  end

  // hold a refused result so the pipe keeps moving for one more request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_q <= 1'b0;
    end else if (skid_q) begin
      if (out_ready_i) begin
        skid_q <= 1'b0;
      end
    end else if (qv_q[4] && !out_ready_i) begin
      skid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_q && qv_q[4] && !out_ready_i) begin
      skid_data_q <= res_q;
    end
  end

  assign out_valid_o = skid_q || qv_q[4];
  assign out_data_o  = skid_q ? skid_data_q : res_q;

`ifndef SYNTHESIS
  a_skid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_q && !out_ready_i |=> skid_q && $stable(skid_data_q))
    else $error("skid register lost a refused result");

  a_press_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.pressure_valid == (out_data_o.pressure_q8 != '0))
    else $error("pressure flag disagrees with pressure value");

  a_temp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.temperature_centi >= TEMP_MIN
                    && out_data_o.temperature_centi <= TEMP_MAX)
    else $error("temperature outside clamp range");
`endif

endmodule
`default_nettype wire

// ----- dv/baro_compensation_checker.sv -----
// Checker for the barometric compensation core: snoops trim writes, predicts
// each compensated reading and compares it with the core's result channel.
// Depends on bsc_pkg.
`timescale 1ns / 100ps
module baro_compensation_checker import bsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_t         in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_t        out_data_i,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  input  logic        pready,
  output int          fail_count_o,
  output int          pending_o
);

  logic [47:0] trim_temp;
  logic [63:0] trim_plow;
  logic [63:0] trim_phigh;
  logic [15:0] trim_plast;
  out_t        expected_readings[$];

  function automatic longint floor_shift(longint v, int n);
    return v >>> n;
  endfunction

  function automatic out_t compensate_reading(in_t r);
    longint adc_p, adc_t, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    longint a, d, b, fine, temp, v1, v2, acc, hi, lo, dv, press, m, p, s, c9, c8, mag;
    longint unsigned um, ud, q1, r1, qm;
    logic neg;
    out_t o;
    adc_p = longint'(r.raw_pressure);
    adc_t = longint'(r.raw_temperature);
    t1 = longint'(trim_temp[15:0]);
    t2 = longint'($signed(trim_temp[31:16]));
    t3 = longint'($signed(trim_temp[47:32]));
    p1 = longint'(trim_plow[15:0]);
    p2 = longint'($signed(trim_plow[31:16]));
    p3 = longint'($signed(trim_plow[47:32]));
    p4 = longint'($signed(trim_plow[63:48]));
    p5 = longint'($signed(trim_phigh[15:0]));
    p6 = longint'($signed(trim_phigh[31:16]));
    p7 = longint'($signed(trim_phigh[47:32]));
    p8 = longint'($signed(trim_phigh[63:48]));
    p9 = longint'($signed(trim_plast));

    a = floor_shift(((adc_t >>> 3) - t1 * 2) * t2, 11);
    d = (adc_t >>> 4) - t1;
    b = floor_shift(floor_shift(d * d, 12) * t3, 14);
    fine = a + b;
    temp = floor_shift(fine * 5 + 128, 8);
    if (temp < -4000) temp = -4000;
    if (temp > 8500) temp = 8500;

    v1 = fine - 128000;
    v2 = v1 * v1 * p6 + v1 * p5 * 131072 + p4 * (longint'(1) <<< 35);
    acc = floor_shift(v1 * v1 * p3, 8) + v1 * p2 * 4096 + (longint'(1) <<< 47);
    hi = floor_shift(acc, 17);
    lo = acc - hi * 131072;
    dv = floor_shift(hi * p1 + ((lo * p1) >>> 17), 16);

    press = 0;
    if (dv != 0) begin
      m = (1048576 - adc_p) * (longint'(1) <<< 31) - v2;
      neg = (m < 0) != (dv < 0);
      um = (m < 0) ? longint'(-m) : m;
      ud = (dv < 0) ? longint'(-dv) : dv;
      q1 = um / ud;
      r1 = um % ud;
      if (q1 >= (64'd1 << 24)) begin
        mag = longint'(1) <<< 35;
      end else begin
        qm = q1 * 3125 + (r1 * 3125) / ud;
        mag = (qm > (64'd1 << 35)) ? (longint'(1) <<< 35) : longint'(qm);
      end
      p = neg ? -mag : mag;
      s = floor_shift(p, 13);
      c9 = floor_shift(p9 * s * s, 25);
      c8 = floor_shift(p8 * p, 19);
      press = floor_shift(p + c9 + c8, 8) + p7 * 16;
      if (press < 0) press = 0;
      if (press > 33554431) press = 33554431;
    end
    o.temperature_centi = temp[14:0];
    o.pressure_q8 = press[24:0];
    o.pressure_valid = press > 0;
    return o;
  endfunction

  assign pending_o = expected_readings.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    out_t e;
    int   errs;
    if (!rst_ni) begin
      trim_temp <= '0;
      trim_plow <= '0;
      trim_phigh <= '0;
      trim_plast <= '0;
      fail_count_o <= 0;
      expected_readings.delete();
    end else begin
      errs = 0;
      if (psel && penable && pwrite && pready) begin
        case (cfg_reg_e'(paddr[4:3]))
          CFG_TRIM_TEMP:  trim_temp <= pwdata[47:0];
          CFG_TRIM_PLOW:  trim_plow <= pwdata;
          CFG_TRIM_PHIGH: trim_phigh <= pwdata;
          CFG_TRIM_PLAST: trim_plast <= pwdata[15:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i)
        expected_readings.push_back(compensate_reading(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_readings.size() == 0) begin
          $error("unexpected result %h", out_data_i);
          errs++;
        end else begin
          e = expected_readings.pop_front();
          if (e.temperature_centi !== out_data_i.temperature_centi) begin
            $error("temperature_centi exp %0d got %0d", e.temperature_centi,
                   out_data_i.temperature_centi);
            errs++;
          end
          if (e.pressure_q8 !== out_data_i.pressure_q8) begin
            $error("pressure_q8 exp %0d got %0d", e.pressure_q8, out_data_i.pressure_q8);
            errs++;
          end
          if (e.pressure_valid !== out_data_i.pressure_valid) begin
            $error("pressure_valid exp %0d got %0d", e.pressure_valid,
                   out_data_i.pressure_valid);
            errs++;
          end
        end
      end
      if (errs != 0)
        fail_count_o <= fail_count_o + errs;
    end
  end

endmodule

// ----- dv/tb_baro_sensor_compensation_core.sv -----
// Testbench top for the barometric compensation core: drives trims and raw
// readings, stalls the result channel and gives the verdict.
// Depends on bsc_pkg, baro_sensor_compensation_core and baro_compensation_checker.
`timescale 1ns / 100ps
module tb_baro_sensor_compensation_core;
  import bsc_pkg::*;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid_i = 0;
  logic        in_ready_o;
  in_t         in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 0;
  out_t        out_data_o;
  logic        psel = 0;
  logic        penable = 0;
  logic        pwrite = 0;
  logic [4:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;
  int          burst_left = 0;
  int          stall_mode = 0;
  int          stall_count = 0;

  baro_sensor_compensation_core dut (.*);

  baro_compensation_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk_i) begin
    if (stall_count == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_count <= $urandom_range(20, 120);
    end else begin
      stall_count <= stall_count - 1;
    end
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= 1'($urandom_range(0, 1));
      default: out_ready_i <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic write_trim(cfg_reg_e idx, logic [63:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic load_trims(logic [47:0] t, logic [63:0] pl, logic [63:0] ph,
                            logic [15:0] p9);
    write_trim(CFG_TRIM_TEMP, {16'h0, t});
    write_trim(CFG_TRIM_PLOW, pl);
    write_trim(CFG_TRIM_PHIGH, ph);
    write_trim(CFG_TRIM_PLAST, {48'h0, p9});
  endtask

  task automatic send_reading(logic [19:0] rp, logic [19:0] rt);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i <= '{raw_pressure: rp, raw_temperature: rt};
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic random_readings(int n);
    logic [19:0] rp, rt;
    repeat (n) begin
      case ($urandom_range(0, 3))
        0: begin
          rp = 20'($urandom);
          rt = 20'($urandom);
        end
        1: begin
          rp = 20'(415148 + $urandom_range(0, 200000) - 100000);
          rt = 20'(519888 + $urandom_range(0, 100000) - 50000);
        end
        2: begin
          rp = $urandom_range(0, 1) ? 20'hFFFFF - 20'($urandom_range(0, 15))
                                    : 20'($urandom_range(0, 15));
          rt = $urandom_range(0, 1) ? 20'hFFFFF - 20'($urandom_range(0, 15))
                                    : 20'($urandom_range(0, 15));
        end
        default: begin
          rp = 20'($urandom_range(200000, 700000));
          rt = 20'($urandom_range(300000, 800000));
        end
      endcase
      send_reading(rp, rt);
    end
  endtask

  localparam logic [47:0] TYP_T  = {16'hFC18, 16'd26435, 16'd27504};
  localparam logic [63:0] TYP_PL = {16'd2855, 16'd3024, 16'hD843, 16'd36477};
  localparam logic [63:0] TYP_PH = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // zero trims: divisor is zero
    send_reading(20'd0, 20'd0);
    send_reading(20'hFFFFF, 20'hFFFFF);
    send_reading(20'd415148, 20'd519888);
    drain();

    load_trims(TYP_T, TYP_PL, TYP_PH, 16'd6000);
    send_reading(20'd415148, 20'd519888);
    send_reading(20'd0, 20'd0);
    send_reading(20'hFFFFF, 20'hFFFFF);
    send_reading(20'd0, 20'hFFFFF);
    send_reading(20'hFFFFF, 20'd0);
    send_reading(20'd300000, 20'd400000);
    send_reading(20'd600000, 20'd650000);
    drain();

    // extreme trims: saturation on both sides
    load_trims('1, '1, '1, 16'hFFFF);
    send_reading(20'd0, 20'hFFFFF);
    send_reading(20'hFFFFF, 20'd0);
    send_reading(20'd524288, 20'd524288);
    drain();
    load_trims({16'h7FFF, 16'h7FFF, 16'h0000}, {16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF},
               {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF}, 16'h8000);
    send_reading(20'd0, 20'hFFFFF);
    send_reading(20'hFFFFF, 20'hFFFFF);
    send_reading(20'd12345, 20'd0);
    drain();
    load_trims({16'h8000, 16'h8000, 16'hFFFF}, {16'h8000, 16'h7FFF, 16'h8000, 16'h0001},
               {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000}, 16'h7FFF);
    send_reading(20'd0, 20'd0);
    send_reading(20'hFFFFF, 20'h80000);
    drain();

    load_trims(TYP_T, TYP_PL, TYP_PH, 16'd6000);
    random_readings(400);
    drain();

    repeat (4) begin
      load_trims(48'({$urandom, $urandom}), {$urandom, $urandom},
                 {$urandom, $urandom}, 16'($urandom));
      random_readings(80);
      drain();
    end

    load_trims({TYP_T[47:16] ^ ($urandom & 32'h00FF00FF), TYP_T[15:0]},
               TYP_PL ^ {$urandom & 32'h00FF00FF, 32'h0}, TYP_PH ^ {32'h0, $urandom & 32'h00FF0000},
               16'(6000 + $urandom_range(0, 2000)));
    random_readings(350);
    drain();

    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/bsc_pkg.sv
rtl/core/bsc_div.sv
rtl/core/baro_sensor_compensation_core.sv
dv/baro_compensation_checker.sv
dv/tb_baro_sensor_compensation_core.sv
